[hdl/footprint_corner_transform_macros.svh]
// ---------------------------------------------------------------------------
// footprint corner transform assertion macros
// shared property forms for the pipeline checks
// ---------------------------------------------------------------------------
`ifndef FOOTPRINT_CORNER_TRANSFORM_MACROS_SVH
`define FOOTPRINT_CORNER_TRANSFORM_MACROS_SVH

// implication checked every clock outside reset
`define FCT_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define FCT_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

[hdl/fct_pkg.sv]
// ---------------------------------------------------------------------------
// fct_pkg
// shared constants and types of the footprint corner transform
// ---------------------------------------------------------------------------
package fct_pkg;

  localparam int CordicSteps = 16;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [32:0] GainQ30 = 33'sd652032874;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  localparam logic [1:0] RegFront = 2'd0;
  localparam logic [1:0] RegBack  = 2'd1;
  localparam logic [1:0] RegHalf  = 2'd2;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] r;
    begin
      case (i)
        4'd0: r = 20'sd51472;
        4'd1: r = 20'sd30385;
        4'd2: r = 20'sd16055;
        4'd3: r = 20'sd8150;
        4'd4: r = 20'sd4091;
        4'd5: r = 20'sd2047;
        4'd6: r = 20'sd1024;
        4'd7: r = 20'sd512;
        4'd8: r = 20'sd256;
        4'd9: r = 20'sd128;
        4'd10: r = 20'sd64;
        4'd11: r = 20'sd32;
        4'd12: r = 20'sd16;
        4'd13: r = 20'sd8;
        4'd14: r = 20'sd4;
        default: r = 20'sd2;
      endcase
      return r;
    end
  endfunction

  // center of one pose in flight alongside the angle pipeline
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } center_t;

  typedef struct packed {
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
    logic signed [15:0] sy;
    logic signed [15:0] cy;
  } trig_t;

endpackage

[hdl/footprint_corner_transform.sv]
// ---------------------------------------------------------------------------
// footprint_corner_transform
// foot pose to four rotated sole corners, saturated q16.16
// ---------------------------------------------------------------------------
// A pose is taken when start is high and busy is low; busy stays high after
// each accepted pose until the gap counter runs down, so poses are taken
// only as fast as the four corner words each one produces leave the single result
// channel. The corner words come out once the pose has passed the pipeline (17
// cordic stages, 3 matrix stages, 1 serializer load, 3 corner stages) back to
// back, each marked by done for one cycle, in the order
// front-left, front-right, back-right, back-left, with last_corner on the
// fourth. The receiver cannot stall, so nothing holds the pipeline.
// Configuration writes are for idle time only.
module footprint_corner_transform
  import fct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // pose command
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  // corner words
  output logic               done,
  output logic signed [31:0] corner_x,
  output logic signed [31:0] corner_y,
  output logic signed [31:0] corner_z,
  output logic        [1:0]  corner_number,
  output logic               last_corner,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  `include "footprint_corner_transform_macros.svh"

  // registers
  logic signed [20:0] front_offset;
  logic signed [20:0] back_offset;
  logic        [19:0] half_width;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_offset <= 21'sd9830;
      back_offset <= -21'sd7209;
      half_width <= 20'd4260;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegFront: front_offset <= pwdata[20:0];
        RegBack: back_offset <= pwdata[20:0];
        RegHalf: half_width <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegFront: prdata = 32'(front_offset);
      RegBack: prdata = 32'(back_offset);
      RegHalf: prdata = {12'd0, half_width};
      default: prdata = '0;
    endcase
  end

  // pacing: busy holds off a new pose while the gap counter runs down
  logic [1:0] gap;
  logic       take;

  assign take = start && !busy;
  assign busy = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (take) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // three cordic lanes in lockstep; center rides a matching delay line
  logic  vr, vp, vy;
  trig_t trig;

  fct_cordic u_roll (.clk, .rst, .in_valid(take), .angle(roll_angle),
    .out_valid(vr), .sin_q14(trig.sr), .cos_q14(trig.cr));
  fct_cordic u_pitch (.clk, .rst, .in_valid(take), .angle(pitch_angle),
    .out_valid(vp), .sin_q14(trig.sp), .cos_q14(trig.cp));
  fct_cordic u_yaw (.clk, .rst, .in_valid(take), .angle(yaw_angle),
    .out_valid(vy), .sin_q14(trig.sy), .cos_q14(trig.cy));

  localparam int CenterDelay = CordicSteps + 1;
  center_t cline [CenterDelay];

  always_ff @(posedge clk) begin
    cline[0] <= '{cx: center_x, cy: center_y, cz: center_z};
    for (int k = 1; k < CenterDelay; k++) begin
      cline[k] <= cline[k-1];
    end
  end

  // rotation columns
  logic               mv;
  center_t            mc;
  logic signed [29:0] a0, b0, c0, a1, b1, c1;

  fct_matrix u_matrix (.clk, .rst, .in_valid(vr), .trig,
    .cin(cline[CenterDelay-1]), .out_valid(mv), .cout(mc),
    .a0, .b0, .c0, .a1, .b1, .c1);

  // corner serializer and output register
  fct_corner u_corner (.clk, .rst, .in_valid(mv), .cin(mc),
    .a0, .b0, .c0, .a1, .b1, .c1,
    .front_offset, .back_offset, .half_width,
    .done, .corner_x, .corner_y, .corner_z, .corner_number, .last_corner);

  `FCT_ASSERT_IMPL(a_lanes_aligned, vr || vp || vy, vr && vp && vy)
  `FCT_ASSERT_NEXT(a_busy_after_take, take, busy)
  `FCT_ASSERT_IMPL(a_no_take_busy, busy, !take)

endmodule

[hdl/fct_cordic.sv]
// ---------------------------------------------------------------------------
// fct_cordic
// pipelined rotation cordic, one stage per step, sine and cosine in q14
// ---------------------------------------------------------------------------
module fct_cordic
  import fct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);

  // 17 register stages: range fold, 16 steps
  logic               vld [CordicSteps+1];
  logic signed [32:0] xs  [CordicSteps+1];
  logic signed [32:0] ys  [CordicSteps+1];
  logic signed [19:0] zs  [CordicSteps+1];
  logic               ng  [CordicSteps+1];

  logic signed [16:0] a_wrap;
  logic signed [16:0] a_fold;
  logic               a_neg;

  always_comb begin
    a_wrap = 17'(angle);
    if (a_wrap > 17'(PiQ13)) begin
      a_wrap = a_wrap - TwoPiQ13;
    end else if (a_wrap < -17'(PiQ13)) begin
      a_wrap = a_wrap + TwoPiQ13;
    end
    a_fold = a_wrap;
    a_neg = 1'b0;
    if (a_wrap > 17'(HalfPiQ13)) begin
      a_fold = a_wrap - 17'(PiQ13);
      a_neg = 1'b1;
    end else if (a_wrap < -17'(HalfPiQ13)) begin
      a_fold = a_wrap + 17'(PiQ13);
      a_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    xs[0] <= GainQ30;
    ys[0] <= '0;
    zs[0] <= {a_fold, 3'b000};
    ng[0] <= a_neg;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q16(4'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q16(4'(i));
      end
      ng[i+1] <= ng[i];
    end
  end

  logic signed [32:0] xr;
  logic signed [32:0] yr;
  logic signed [16:0] cq;
  logic signed [16:0] sq;

  always_comb begin
    xr = (xs[CordicSteps] + 33'sd32768) >>> 16;
    yr = (ys[CordicSteps] + 33'sd32768) >>> 16;
    cq = 17'(xr);
    sq = 17'(yr);
    if (xr > 33'(OneQ14)) cq = 17'(OneQ14);
    if (xr < -33'(OneQ14)) cq = -17'(OneQ14);
    if (yr > 33'(OneQ14)) sq = 17'(OneQ14);
    if (yr < -33'(OneQ14)) sq = -17'(OneQ14);
    if (ng[CordicSteps]) begin
      cq = -cq;
      sq = -sq;
    end
  end

  assign out_valid = vld[CordicSteps];
  assign cos_q14 = 16'(cq);
  assign sin_q14 = 16'(sq);

endmodule

[hdl/fct_matrix.sv]
// ---------------------------------------------------------------------------
// fct_matrix
// builds the two rotation columns seen by the sole plane, q28
// ---------------------------------------------------------------------------
module fct_matrix
  import fct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  trig_t              trig,
  input  center_t            cin,
  output logic               out_valid,
  output center_t            cout,
  output logic signed [29:0] a0,
  output logic signed [29:0] b0,
  output logic signed [29:0] c0,
  output logic signed [29:0] a1,
  output logic signed [29:0] b1,
  output logic signed [29:0] c1
);

  // stage 1: triple product factors rounded to q14
  logic         v1;
  center_t      c1r;
  trig_t        t1;
  logic signed [15:0] srsp;
  logic signed [15:0] crsp;
  logic signed [31:0] p_srsp;
  logic signed [31:0] p_crsp;

  assign p_srsp = (trig.sr * trig.sp + 32'sd8192) >>> 14;
  assign p_crsp = (trig.cr * trig.sp + 32'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    c1r <= cin;
    t1 <= trig;
    srsp <= 16'(p_srsp);
    crsp <= 16'(p_crsp);
  end

  // stage 2: matrix products
  logic signed [29:0] m_cpcy, m_srspcy, m_crsy, m_crspcy, m_srsy;
  logic signed [29:0] m_cpsy, m_srspsy, m_crcy, m_crspsy, m_srcy;
  logic    v2;
  center_t c2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    c2r <= c1r;
    m_cpcy   <= 30'(t1.cp * t1.cy);
    m_srspcy <= 30'(srsp * t1.cy);
    m_crsy   <= 30'(t1.cr * t1.sy);
    m_crspcy <= 30'(crsp * t1.cy);
    m_srsy   <= 30'(t1.sr * t1.sy);
    m_cpsy   <= 30'(t1.cp * t1.sy);
    m_srspsy <= 30'(srsp * t1.sy);
    m_crcy   <= 30'(t1.cr * t1.cy);
    m_crspsy <= 30'(crsp * t1.sy);
    m_srcy   <= 30'(t1.sr * t1.cy);
  end

  // stage 3: sums, each bounded by 2^29
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    cout <= c2r;
    a0 <= m_cpcy;
    b0 <= m_srspcy + m_crsy;
    c0 <= m_srsy - m_crspcy;
    a1 <= -m_cpsy;
    b1 <= m_crcy - m_srspsy;
    c1 <= m_crspsy + m_srcy;
  end

endmodule

[hdl/fct_corner.sv]
// ---------------------------------------------------------------------------
// fct_corner
// serializes four corners per pose and applies rotation and offset
// ---------------------------------------------------------------------------
module fct_corner
  import fct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  center_t            cin,
  input  logic signed [29:0] a0,
  input  logic signed [29:0] b0,
  input  logic signed [29:0] c0,
  input  logic signed [29:0] a1,
  input  logic signed [29:0] b1,
  input  logic signed [29:0] c1,
  input  logic signed [20:0] front_offset,
  input  logic signed [20:0] back_offset,
  input  logic        [19:0] half_width,
  output logic               done,
  output logic signed [31:0] corner_x,
  output logic signed [31:0] corner_y,
  output logic signed [31:0] corner_z,
  output logic        [1:0]  corner_number,
  output logic               last_corner
);

  `include "footprint_corner_transform_macros.svh"

  // held pose, stepped through four corners
  logic               act;
  logic [1:0]         cnt;
  center_t            hc;
  logic signed [29:0] ha0, hb0, hc0, ha1, hb1, hc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      cnt <= '0;
    end else if (in_valid) begin
      act <= 1'b1;
      cnt <= '0;
    end else if (act) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) act <= 1'b0;
    end
    if (in_valid) begin
      hc <= cin;
      ha0 <= a0; hb0 <= b0; hc0 <= c0;
      ha1 <= a1; hb1 <= b1; hc1 <= c1;
    end
  end

  logic signed [20:0] u;
  logic signed [20:0] v;

  always_comb begin
    u = cnt[1] ? back_offset : front_offset;
    v = (cnt == 2'd0 || cnt == 2'd3) ? $signed({1'b0, half_width})
                                     : -$signed({1'b0, half_width});
  end

  // product stage
  logic               pv;
  logic [1:0]         pn;
  center_t            pc;
  logic signed [50:0] pxu, pxv, pyu, pyv, pzu, pzv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= act;
    end
    pn <= cnt;
    pc <= hc;
    pxu <= 51'(ha0 * u); pxv <= 51'(ha1 * v);
    pyu <= 51'(hb0 * u); pyv <= 51'(hb1 * v);
    pzu <= 51'(hc0 * u); pzv <= 51'(hc1 * v);
  end

  // round, add center
  logic               sv;
  logic [1:0]         sn;
  logic signed [33:0] sx, sy, sz;

  function automatic logic signed [33:0] rnd_add(input logic signed [50:0] p,
                                                  input logic signed [50:0] q,
                                                  input logic signed [31:0] c);
    logic signed [51:0] s;
    begin
      s = (52'(p) + 52'(q) + 52'sd134217728) >>> 28;
      return 34'(s) + 34'(c);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else begin
      sv <= pv;
    end
    sn <= pn;
    sx <= rnd_add(pxu, pxv, pc.cx);
    sy <= rnd_add(pyu, pyv, pc.cy);
    sz <= rnd_add(pzu, pzv, pc.cz);
  end

  function automatic logic signed [31:0] sat(input logic signed [33:0] s);
    begin
      if (s > 34'sd2147483647) return 32'sh7fffffff;
      if (s < -34'sd2147483648) return 32'sh80000000;
      return 32'(s);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv;
    end
    corner_x <= sat(sx);
    corner_y <= sat(sy);
    corner_z <= sat(sz);
    corner_number <= sn;
    last_corner <= (sn == 2'd3);
  end

  `FCT_ASSERT_NEXT(a_cnt_steps, act && !in_valid && cnt != 2'd3, act && cnt == $past(cnt) + 2'd1)
  `FCT_ASSERT_IMPL(a_last_num, done, last_corner == (corner_number == 2'd3))
  `FCT_ASSERT_NEXT(a_seq, done && !last_corner, done)

endmodule
